/* rtl/bgdg_pkg.sv */
// Shared types and constants for the GRBG Bayer demosaic with grey output.
// No dependencies; used by every module of the block.
package bgdg_pkg;

   localparam int DEFAULT_MAX_WIDTH = 512;

   localparam int PIX_W     = 8;
   localparam int LINE_W    = 2 * PIX_W;   // upper and middle row sample side by side
   localparam int ROW_W     = 12;
   localparam int COL_OUT_W = 9;
   localparam int IWID_W    = 10;          // image_width register
   localparam int IHGT_W    = 12;          // image_height register
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;
   localparam int RSP_DAT_W = 56;          // 53 bits of fields padded to whole bytes

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [IWID_W-1:0] RESET_WIDTH  = 10'd512;
   localparam logic [IHGT_W-1:0] RESET_HEIGHT = 12'd512;
   localparam logic [IHGT_W-1:0] MIN_SIZE     = 12'd3;

   // Luma weights 0.2125, 0.7154, 0.0721 in Q0.16
   localparam int WEIGHT_RED   = 13926;
   localparam int WEIGHT_GREEN = 46884;
   localparam int WEIGHT_BLUE  = 4725;

   // 3x3 neighbourhood: [row][column], row 0 is the oldest line, column 2 the newest sample
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [PIX_W-1:0] grey;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } colour_type;

endpackage

/* rtl/bayer_grbg_demosaic_grey.sv */
// Top level of the GRBG Bayer demosaic with grey output.
// Depends on bgdg_pkg, bgdg_line_store and bgdg_interp.
//
// Raw GRBG samples enter one word per cycle in raster order on the req_ stream;
// req_tuser marks the first sample of a frame and resets the position to column 0,
// row 0. The block keeps two line stores and a 3x3 window and, for every interior
// pixel, sends one rsp_ word carrying red, green, blue, grey and the centre position,
// with rsp_tlast on the final interior pixel of the frame. Border rows and columns
// give no word. The sustained rate is one sample per cycle while the output is not
// stalled; a sample's result passes through the registered line store read, the window
// shift and the colour and grey stage feeding the output register. Sizes are written
// on the csr_ channel while the stream is idle; widths saturate to 3..MAX_WIDTH and
// heights to 3..4095. Line store contents are not cleared at reset, so the first two
// rows after reset must be fed before any interior result depends on them.
module bayer_grbg_demosaic_grey #(
   parameter int MAX_WIDTH = bgdg_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] raw_pixel
   input  logic [0:0]                         req_tuser,  // [0] frame_start
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] grey,
   // [40:32] center_column, [52:41] center_row, [55:53] zero
   output logic [bgdg_pkg::RSP_DAT_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,  // last_of_frame
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bgdg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgdg_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   // wide enough for the width register, MAX_WIDTH itself and one more
   localparam int WCMP = ((CW + 1 > bgdg_pkg::IWID_W) ? CW + 1 : bgdg_pkg::IWID_W) + 1;
   localparam int RW   = bgdg_pkg::ROW_W;

   // ---------------------------------------------------------------- configuration
   logic [bgdg_pkg::IWID_W-1:0] width_ff;
   logic [bgdg_pkg::IHGT_W-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bgdg_pkg::RESET_WIDTH;
         height_ff <= bgdg_pkg::RESET_HEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            bgdg_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[bgdg_pkg::IWID_W-1:0];
            bgdg_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data[bgdg_pkg::IHGT_W-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Saturated sizes in effect
   logic [WCMP-1:0] w_eff;
   logic [RW:0]     h_eff;

   always_comb begin
      priority if (WCMP'(width_ff) < WCMP'(bgdg_pkg::MIN_SIZE)) begin
         w_eff = WCMP'(bgdg_pkg::MIN_SIZE);
      end else if (WCMP'(width_ff) > WCMP'(MAX_WIDTH)) begin
         w_eff = WCMP'(MAX_WIDTH);
      end else begin
         w_eff = WCMP'(width_ff);
      end
      h_eff = (height_ff < bgdg_pkg::MIN_SIZE) ? (RW + 1)'(bgdg_pkg::MIN_SIZE)
                                               : (RW + 1)'(height_ff);
   end

   // ---------------------------------------------------------------- handshake chain
   logic valid_a_ff, valid_b_ff, rsp_valid_ff;
   logic emit_a_ff, emit_b_ff;
   logic accept, a_go, b_go, b_free;

   // stage B drains when it has nothing to send or the output register frees up
   assign b_go       = valid_b_ff && (!emit_b_ff || !rsp_valid_ff || rsp_tready);
   assign b_free     = !valid_b_ff || b_go;
   assign a_go       = valid_a_ff && b_free;
   assign req_tready = !valid_a_ff || a_go;
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------- position
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   c_now;
   logic [RW-1:0]   r_now;
   logic [WCMP-1:0] c_ext, c_inc, x_full;
   logic [RW:0]     r_ext, r_inc;
   logic            emit_in, last_in;

   assign c_now  = req_tuser[0] ? '0 : col_ff;
   assign r_now  = req_tuser[0] ? '0 : row_ff;
   assign c_ext  = WCMP'(c_now);
   assign c_inc  = c_ext + WCMP'(1);
   assign x_full = c_ext - WCMP'(1);
   assign r_ext  = (RW + 1)'(r_now);
   assign r_inc  = r_ext + (RW + 1)'(1);

   always_comb begin
      // advance along the row, wrap to the next row, wrap the frame
      if (c_inc >= w_eff) begin
         col_in = '0;
         row_in = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
      end else begin
         col_in = c_inc[CW-1:0];
         row_in = r_now;
      end
      emit_in = (c_ext >= WCMP'(2)) && (r_ext >= (RW + 1)'(2))
             && (c_ext < w_eff) && (r_ext < h_eff);
      last_in = (c_inc == w_eff) && (r_inc == h_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage A: line read
   logic [7:0]                  px_a_ff;
   logic [CW-1:0]               col_a_ff;
   logic [8:0]                  x_a_ff;
   logic [RW-1:0]               y_a_ff;
   logic                        last_a_ff;
   logic                        fwd_ff;
   logic [bgdg_pkg::LINE_W-1:0] fwd_data_ff;
   logic [bgdg_pkg::LINE_W-1:0] ram_rd, rd_eff, wr_word;
   logic                        fwd_in;

   // The word leaving stage A writes its column on the same edge that the next word
   // reads; when both hit one column the read sees stale data, so forward instead.
   assign rd_eff  = fwd_ff ? fwd_data_ff : ram_rd;
   assign wr_word = {rd_eff[7:0], px_a_ff};   // middle row moves up, new sample in
   assign fwd_in  = a_go && (col_a_ff == c_now);

   bgdg_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_now),
      .rd_data (ram_rd),
      .wr_en   (a_go),
      .wr_addr (col_a_ff),
      .wr_data (wr_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (accept) begin
         valid_a_ff <= 1'b1;
      end else if (a_go) begin
         valid_a_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_a_ff     <= req_tdata;
         col_a_ff    <= c_now;
         x_a_ff      <= x_full[8:0];
         y_a_ff      <= r_now - RW'(1);
         emit_a_ff   <= emit_in;
         last_a_ff   <= last_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_word;
      end
   end

   // ---------------------------------------------------------------- stage B: window
   bgdg_pkg::window_type win_ff;
   logic [8:0]           x_b_ff;
   logic [RW-1:0]        y_b_ff;
   logic                 last_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
         win_ff     <= '0;
      end else begin
         if (a_go) begin
            valid_b_ff <= 1'b1;
            // shift left, bring in the new column: upper, middle, current row
            for (int k = 0; k < 3; k++) begin
               win_ff[k][0] <= win_ff[k][1];
               win_ff[k][1] <= win_ff[k][2];
            end
            win_ff[0][2] <= rd_eff[15:8];
            win_ff[1][2] <= rd_eff[7:0];
            win_ff[2][2] <= px_a_ff;
         end else if (b_go) begin
            valid_b_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         x_b_ff    <= x_a_ff;
         y_b_ff    <= y_a_ff;
         emit_b_ff <= emit_a_ff;
         last_b_ff <= last_a_ff;
      end
   end

   // ---------------------------------------------------------------- colour and output
   bgdg_pkg::colour_type        pix;
   logic [bgdg_pkg::RSP_DAT_W-1:0] rsp_data_ff;
   logic                        rsp_last_ff;

   bgdg_interp u_interp (
      .win   (win_ff),
      .x_odd (x_b_ff[0]),
      .y_odd (y_b_ff[0]),
      .pix   (pix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go && emit_b_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go && emit_b_ff) begin
         rsp_data_ff <= {3'b000, y_b_ff, x_b_ff, pix.grey, pix.blue, pix.green, pix.red};
         rsp_last_ff <= last_b_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   // The column counter never leaves the line store's address range
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(col_ff) < (CW + 1)'(MAX_WIDTH))
      else $error("column counter beyond line store depth");

   // A stalled window stage must not shift
   a_win_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_b_ff && !b_go) |=> $stable(win_ff))
      else $error("window shifted while its word was stalled");

   // A result appears only from a word of stage B that produces one
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_b_ff && emit_b_ff))
      else $error("result word without a producing window word");

   // Forwarding is only armed for a word that sits in stage A
   a_fwd_owner: assert property (@(posedge clock) disable iff (reset)
      (fwd_ff && !valid_a_ff) |=> !a_go)
      else $error("line store forward used without a word in stage A");

endmodule

/* rtl/bgdg_line_store.sv */
// Two line stores held as one memory word per column: {upper row, middle row}.
// One write port, one read port with registered read data. Uses bgdg_pkg.
module bgdg_line_store #(
   parameter int DEPTH = bgdg_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [bgdg_pkg::LINE_W-1:0]     rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [bgdg_pkg::LINE_W-1:0]     wr_data
);

   logic [bgdg_pkg::LINE_W-1:0] mem_ff [DEPTH];
   logic [bgdg_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bgdg_interp.sv */
// Bilinear colour reconstruction of the window centre and the Q8.16 grey sum.
// Purely combinational. Uses bgdg_pkg.
module bgdg_interp (
   input  bgdg_pkg::window_type win,
   input  logic                 x_odd,
   input  logic                 y_odd,
   output bgdg_pkg::colour_type pix
);

   logic [7:0]  ctr;
   logic [8:0]  lr;
   logic [8:0]  ud;
   logic [9:0]  cr;
   logic [9:0]  edges;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [23:0] luma;

   assign ctr   = win[1][1];
   assign lr    = 9'(win[1][0]) + 9'(win[1][2]);
   assign ud    = 9'(win[0][1]) + 9'(win[2][1]);
   assign cr    = 10'(win[0][0]) + 10'(win[0][2]) + 10'(win[2][0]) + 10'(win[2][2]);
   assign edges = 10'(lr) + 10'(ud);

   // Parity picks which colour is native at the centre
   always_comb begin
      unique case ({y_odd, x_odd})
         2'b00: begin
            green = ctr;         red  = lr[8:1];      blue = ud[8:1];
         end
         2'b01: begin
            red   = ctr;         green = edges[9:2];  blue = cr[9:2];
         end
         2'b10: begin
            blue  = ctr;         green = edges[9:2];  red  = cr[9:2];
         end
         default: begin
            green = ctr;         red  = ud[8:1];      blue = lr[8:1];
         end
      endcase
   end

   assign luma = 24'(bgdg_pkg::WEIGHT_RED)   * 24'(red)
               + 24'(bgdg_pkg::WEIGHT_GREEN) * 24'(green)
               + 24'(bgdg_pkg::WEIGHT_BLUE)  * 24'(blue);

   assign pix.red   = red;
   assign pix.green = green;
   assign pix.blue  = blue;
   assign pix.grey  = luma[23:16];

endmodule

/* tb/tb.sv */
// Self-checking testbench for bayer_grbg_demosaic_grey: raw GRBG frames in, colour words out.
// Depends on bgdg_pkg and the RTL top level; needs no files and no arguments.
// A sample-level predictor of the line stores and 3x3 window checks every field of every word.
module tb;
   import bgdg_pkg::*;

   localparam int MAX_COLS       = DEFAULT_MAX_WIDTH;
   localparam int MAX_ROWS       = 4095;
   localparam int RANDOM_PIXELS  = 1250;
   localparam int SETTLE_CYCLES  = 8;     // pipeline is three deep; leave some margin
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 40;

   // Luma weights 0.2125, 0.7154 and 0.0721 scaled by 2^16 and truncated
   localparam int unsigned LUMA_RED   = 13926;
   localparam int unsigned LUMA_GREEN = 46884;
   localparam int unsigned LUMA_BLUE  = 4725;

   // Indexes with no register behind them; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct {
      colour_type           colours;
      logic [COL_OUT_W-1:0] column;
      logic [ROW_W-1:0]     row;
      logic                 last;
   } colour_word_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] raw_pixel
   logic [0:0]            req_tuser;   // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] grey,
   // [40:32] center_column, [52:41] center_row, [55:53] zero
   logic [RSP_DAT_W-1:0]  rsp_tdata;
   logic                  rsp_tlast;   // last_of_frame
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_data;

   // Predictor state: the two previous rows, the 3x3 neighbourhood, the raster position
   logic [PIX_W-1:0]      upper_line [MAX_COLS];
   logic [PIX_W-1:0]      middle_line [MAX_COLS];
   logic [PIX_W-1:0]      nbhd [3][3];
   int unsigned           next_col;
   int unsigned           next_row;
   logic [IWID_W-1:0]     width_reg;
   logic [IHGT_W-1:0]     height_reg;
   colour_word_t          colour_q [$];

   // Stimulus controls and run statistics
   bit                    src_idle_on = 1'b1;
   bit                    sink_idle_on = 1'b1;
   int                    hold_request = 0;
   int                    mismatch_count = 0;
   int                    pixels_taken = 0;
   int                    words_checked = 0;
   int                    frame_ends = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bayer_grbg_demosaic_grey uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void clear_predictor();
      int k;
      for (k = 0; k < MAX_COLS; k++) begin
         upper_line[k] = '0;
         middle_line[k] = '0;
      end
      for (k = 0; k < 9; k++) nbhd[k / 3][k % 3] = '0;
      next_col = 0;
      next_row = 0;
      width_reg = 10'd512;
      height_reg = 12'd512;
      colour_q.delete();
   endfunction

   // Advance the window by one raw sample and queue the colour word it releases, if any
   function automatic void predict_colours(input logic [PIX_W-1:0] px, input logic frame_first);
      int unsigned w, h, c, r, x, y, lr, ud, cr, red, green, blue, k;
      colour_word_t word;
      w = (width_reg < 3) ? 3 : (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
      h = (height_reg < 3) ? 3 : height_reg;
      if (frame_first) begin
         next_col = 0;
         next_row = 0;
      end
      c = next_col;
      r = next_row;
      for (k = 0; k < 3; k++) begin
         nbhd[k][0] = nbhd[k][1];
         nbhd[k][1] = nbhd[k][2];
      end
      nbhd[0][2] = upper_line[c];
      nbhd[1][2] = middle_line[c];
      nbhd[2][2] = px;
      upper_line[c] = middle_line[c];
      middle_line[c] = px;

      if (c >= 2 && r >= 2 && c < w && r < h) begin
         x = c - 1;
         y = r - 1;
         lr = nbhd[1][0] + nbhd[1][2];
         ud = nbhd[0][1] + nbhd[2][1];
         cr = nbhd[0][0] + nbhd[0][2] + nbhd[2][0] + nbhd[2][2];
         // GRBG: green on even/even and odd/odd, red on even row odd column, blue the rest
         if (y[0] == 1'b0 && x[0] == 1'b0) begin
            green = nbhd[1][1]; red = lr >> 1; blue = ud >> 1;
         end else if (y[0] == 1'b0) begin
            red = nbhd[1][1]; green = (lr + ud) >> 2; blue = cr >> 2;
         end else if (x[0] == 1'b0) begin
            blue = nbhd[1][1]; green = (lr + ud) >> 2; red = cr >> 2;
         end else begin
            green = nbhd[1][1]; red = ud >> 1; blue = lr >> 1;
         end
         word.colours.red   = red[7:0];
         word.colours.green = green[7:0];
         word.colours.blue  = blue[7:0];
         word.colours.grey  = 8'((LUMA_RED * red + LUMA_GREEN * green + LUMA_BLUE * blue) >> 16);
         word.column = x[COL_OUT_W-1:0];
         word.row    = y[ROW_W-1:0];
         word.last   = (c == w - 1 && r == h - 1);
         colour_q.push_back(word);
      end

      // Wrap at the row end and at the frame end, with or without a frame start
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endfunction

   function automatic void compare_field(input string name, input int unsigned want, got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // One process sees all three channels, so register writes, samples and words
   // update the predictor in the order the block takes them.
   always @(posedge clock) begin : scoreboard
      colour_word_t want;
      colour_type   got;
      if (reset) begin
         clear_predictor();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_data[IWID_W-1:0];
            else if (csr_index == CSR_IMAGE_HEIGHT) height_reg = csr_data[IHGT_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            predict_colours(req_tdata, req_tuser[0]);
            pixels_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (colour_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: colour word expected none, got %h last %b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = colour_q.pop_front();
               got = colour_type'(rsp_tdata[31:0]);
               compare_field("red", want.colours.red, got.red);
               compare_field("green", want.colours.green, got.green);
               compare_field("blue", want.colours.blue, got.blue);
               compare_field("grey", want.colours.grey, got.grey);
               compare_field("center_column", want.column, rsp_tdata[40:32]);
               compare_field("center_row", want.row, rsp_tdata[52:41]);
               compare_field("padding", 0, rsp_tdata[55:53]);
               compare_field("last_of_frame", want.last, rsp_tlast);
               words_checked++;
               if (want.last) frame_ends++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result sink: random back-pressure bursts, plus one long hold on request
   // ------------------------------------------------------------------

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            if (hold_request != 0) begin
               stall_left = hold_request;
               hold_request = 0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 5);
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort when no word moves on any channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: timeout, no word moved for %0d cycles, %0d words still awaited",
               $time, WATCHDOG_LIMIT, colour_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one raw sample, with an occasional gap before it; hold until taken
   task automatic send_pixel(input logic [7:0] px, input logic frame_first);
      int gap;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= frame_first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Raise a register write and hold until taken; the caller drops csr_valid
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [CSR_DAT_W-1:0] w, h);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // Stop offering, wait for every awaited word, then let the pipeline settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (colour_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random(input int count, input logic frame_first);
      int k;
      for (k = 0; k < count; k++) send_pixel(8'($urandom), frame_first && k == 0);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Smallest frames: saturation from below, all four colour phases, full-scale
   // and zero samples, spare register indexes, and a wrap with no frame start.
   task automatic test_directed_frames();
      int k;
      drain_results();
      set_frame_size(12'd0, 12'd1);           // both saturate up to 3
      for (k = 0; k < 9; k++) send_pixel(8'hFF, k == 0);
      drain_results();
      csr_write(CSR_SPARE_LOW, 12'hFFF);
      csr_write(CSR_SPARE_HIGH, 12'hFFF);
      csr_write(CSR_IMAGE_WIDTH, 12'd4);
      csr_write(CSR_IMAGE_HEIGHT, 12'd4);
      csr_valid <= 1'b0;
      // The last frame ended cleanly, so start this one without a frame start
      for (k = 0; k < 16; k++)
         send_pixel(8'((k % 3 == 0) ? 0 : (k % 3 == 1) ? 255 : k * 37), 1'b0);
   endtask

   // Full-width rows. Also writes every line store entry, so later resizes upwards
   // never read an entry that holds nothing.
   task automatic test_wide_rows();
      drain_results();
      set_frame_size(12'd512, 12'd3);
      send_random(2 * MAX_COLS + 100, 1'b1);
      // Width above the maximum saturates, so the frame carries on unchanged
      drain_results();
      csr_write(CSR_IMAGE_WIDTH, 12'h3FF);
      csr_valid <= 1'b0;
      send_random(MAX_COLS - 100, 1'b0);
   endtask

   // Shrink the width past the current column, shrink the height past the current
   // row, then grow both, all in the middle of a frame.
   task automatic test_midframe_resize();
      drain_results();
      set_frame_size(12'd8, 12'd8);
      send_random(29, 1'b1);
      drain_results();
      csr_write(CSR_IMAGE_WIDTH, 12'd4);
      csr_valid <= 1'b0;
      send_random(10, 1'b0);
      drain_results();
      csr_write(CSR_IMAGE_HEIGHT, 12'd3);
      csr_valid <= 1'b0;
      send_random(14, 1'b0);
      drain_results();
      set_frame_size(12'd10, 12'd6);
      send_random(60, 1'b0);
   endtask

   // Hold the output for a long stretch while samples keep coming, so the block
   // must fill up and push back on its input.
   task automatic test_output_stall();
      drain_results();
      set_frame_size(12'd10, 12'd8);
      hold_request = LONG_HOLD;
      send_random(160, 1'b1);
   endtask

   // Random sizes, mostly small frames; now and then out-of-range sizes, tall frames
   // cut short, a resize mid-frame or a frame start out of place.
   task automatic test_random_frames();
      int unsigned wreg, hreg, w, h, total, resize_at, restart_at, k, done;
      logic fs_next;
      done = 0;
      fs_next = 1'b1;
      while (done < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0: wreg = $urandom_range(0, 2);
            1: wreg = $urandom_range(13, 40);
            default: wreg = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 9))
            0: hreg = $urandom_range(0, 2);
            1: hreg = $urandom_range(11, MAX_ROWS);
            default: hreg = $urandom_range(3, 10);
         endcase
         w = (wreg < 3) ? 3 : wreg;
         h = (hreg < 3) ? 3 : hreg;
         total = (h > 10) ? w * $urandom_range(3, 6) + $urandom_range(0, w - 1) : w * h;
         resize_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : 0;
         restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : 0;
         src_idle_on = ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);

         drain_results();
         // Width bits above the register are junk and must be dropped
         set_frame_size({2'($urandom), 10'(wreg)}, 12'(hreg));
         for (k = 0; k < total; k++) begin
            if (k == resize_at && k != 0) begin
               drain_results();
               if ($urandom_range(0, 1) == 0)
                  csr_write(CSR_IMAGE_WIDTH, 12'($urandom_range(0, 40)));
               else
                  csr_write(CSR_IMAGE_HEIGHT, 12'($urandom_range(0, 12)));
               csr_valid <= 1'b0;
            end
            send_pixel(8'($urandom), (k == 0 && fs_next) || (k == restart_at && k != 0));
         end
         done += total;
         fs_next = ($urandom_range(0, 3) != 0);
      end
   endtask

   // Back-to-back frames with both sides always ready
   task automatic test_unpaced_tail();
      drain_results();
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      set_frame_size(12'd7, 12'd6);
      send_random(3 * 42, 1'b1);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_IMAGE_WIDTH;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_wide_rows();
      test_midframe_resize();
      test_output_stall();
      test_random_frames();
      test_unpaced_tail();
      drain_results();

      $display("Run covered %0d raw samples and %0d colour words, %0d of them frame ends.",
               pixels_taken, words_checked, frame_ends);
      $display("Sizes ran from 3x3 to full width, with resizes mid-frame and a long output hold.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
